// ===== hdl/two_level_page_walk_memory_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-level page walk memory
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_WALK_MEMORY_MACROS_SVH
`define TWO_LEVEL_PAGE_WALK_MEMORY_MACROS_SVH

// same-cycle implication
`define TLPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tlpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared types and constants of the two-level page walk memory.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  localparam int PAGE_SHIFT  = 12;
  localparam int ENTRY_BYTES = 4;
  localparam int MAX_BYTES   = 4;
  localparam int CFG_AW      = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_DIR = 2'd1,
    ST_NO_TBL = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIR   = 9'b000000010,
    S_TBL   = 9'b000000100,
    S_PTE   = 9'b000001000,
    S_CHECK = 9'b000010000,
    S_FETCH = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_RESP  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  // register byte offsets
  localparam logic [CFG_AW-1:0] REG_PAGING_ON = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DIR_BASE  = 3'd4;

endpackage

// ===== hdl/tlpw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_in_if / tlpw_out_if
// Valid/ready channels for access requests and their results.
// ----------------------------------------------------------------------------
interface tlpw_in_if;
  import tlpw_pkg::*;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] virt_addr;
  logic [2:0]  access_len;
  logic [31:0] write_data;
  modport source (output valid, action, virt_addr, access_len, write_data, input ready);
  modport sink (input valid, action, virt_addr, access_len, write_data, output ready);
endinterface

interface tlpw_out_if;
  import tlpw_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  status_t     status;
  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

// ===== hdl/two_level_page_walk_memory.sv =====
`timescale 1ns / 1ps
// Each access moves its bytes one at a time through the single byte port; with paging on,
// a page walk (directory entry, then table entry) comes first, and a page crossing walks twice.
// One item at a time: the next input is taken only once the last item is done, and a
// waiting result does not block the input.
// Reset (rst_n low, synchronous) clears control state and the config registers;
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
// two_level_page_walk_memory
// Byte memory with optional x86-style two-level address translation.
// ----------------------------------------------------------------------------
`include "two_level_page_walk_memory_macros.svh"

module two_level_page_walk_memory #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tlpw_in_if.sink                      in_ch,
  tlpw_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tlpw_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  import tlpw_pkg::*;

  localparam int M = MEM_ADDR_BITS;

  // config
  logic        paging_r;
  logic [19:0] dbf_r;
  logic        cfg_wr;

  // control
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt, out_load;

  // item
  logic        act_r, act_nxt;
  logic [31:0] va_r, va_nxt, mid_r, mid_nxt, wd_r, wd_nxt;
  logic [2:0]  len_r, len_nxt, n0_r, n0_nxt, n1_r, n1_nxt;
  logic        split_r, split_nxt, seg_r, seg_nxt;
  logic [31:0] b0_r, b0_nxt, b1_r, b1_nxt;
  logic [31:0] acc_r, acc_nxt;
  status_t     status_r, status_nxt;

  // fetch / byte sequencer
  logic [M-1:0] a0_r, a0_nxt, a1_r, a1_nxt;
  logic [2:0]   fn0_r, fn0_nxt, lim_r, lim_nxt, cnt_r, cnt_nxt;

  // output
  logic [31:0] out_rd_r;
  status_t     out_st_r;

  // memory port
  logic         mem_we;
  logic [M-1:0] mem_addr;
  logic [7:0]   mem_wdata, mem_q;

  // combinational helpers
  logic [2:0]  len_sat, len_l;
  logic [31:0] last, mid, diff, va_seg, dir_ea, tbl_ea;
  logic        split;
  logic [32:0] end0, end1;
  logic [1:0]  lane;

  // -------- configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_DIR_BASE[2]) ? {12'd0, dbf_r} : {31'd0, paging_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_r <= 1'b0;
      dbf_r    <= 20'd0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_PAGING_ON[2]) begin
        paging_r <= cfg_pwdata[0];
      end else begin
        dbf_r <= cfg_pwdata[19:0];
      end
    end
  end

  // -------- memory
  tlpw_byte_mem #(.ADDR_BITS(M)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  // byte k of the current access: first run at a0, rest at a1
  assign mem_addr  = (cnt_r < fn0_r) ? a0_r + M'(cnt_r) : a1_r + M'(cnt_r - fn0_r);
  assign mem_wdata = wd_r[{cnt_r[1:0], 3'b000} +: 8];

  // -------- request decode
  always_comb begin
    case (in_ch.access_len)
      3'd5, 3'd6, 3'd7: len_sat = 3'd4;
      default:          len_sat = in_ch.access_len;
    endcase
  end

  assign last   = in_ch.virt_addr + 32'(len_sat) - 32'd1;
  assign split  = paging_r && (in_ch.virt_addr[31:PAGE_SHIFT] != last[31:PAGE_SHIFT]);
  assign mid    = {last[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign diff   = mid - in_ch.virt_addr;
  assign len_l  = diff[2:0];

  assign va_seg = seg_r ? mid_r : va_r;
  assign dir_ea = {dbf_r, va_seg[31:22], 2'b00};
  assign tbl_ea = {acc_r[31:PAGE_SHIFT], va_seg[21:PAGE_SHIFT], 2'b00};
  assign end0   = {1'b0, b0_r} + 33'(n0_r) - 33'd1;
  assign end1   = {1'b0, b1_r} + 33'(n1_r) - 33'd1;
  assign lane   = 2'(cnt_r - 3'd1);

  assign in_ch.ready = (state_r == S_IDLE);

  // -------- sequencer
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    act_nxt    = act_r;
    va_nxt     = va_r;
    mid_nxt    = mid_r;
    wd_nxt     = wd_r;
    len_nxt    = len_r;
    n0_nxt     = n0_r;
    n1_nxt     = n1_r;
    split_nxt  = split_r;
    seg_nxt    = seg_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    a0_nxt     = a0_r;
    a1_nxt     = a1_r;
    fn0_nxt    = fn0_r;
    lim_nxt    = lim_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt    = in_ch.action;
          va_nxt     = in_ch.virt_addr;
          mid_nxt    = mid;
          wd_nxt     = in_ch.write_data;
          len_nxt    = len_sat;
          n0_nxt     = split ? len_l : len_sat;
          n1_nxt     = split ? len_sat - len_l : 3'd0;
          split_nxt  = split;
          seg_nxt    = 1'b0;
          b0_nxt     = in_ch.virt_addr;
          acc_nxt    = 32'd0;
          status_nxt = ST_OK;
          if (len_sat == 3'd0) begin
            state_nxt = S_RESP;
          end else if (paging_r) begin
            state_nxt = S_DIR;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_DIR: begin
        if (|dir_ea[31:M]) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_RESP;
        end else begin
          a0_nxt    = dir_ea[M-1:0];
          fn0_nxt   = 3'(ENTRY_BYTES);
          lim_nxt   = 3'(ENTRY_BYTES);
          cnt_nxt   = 3'd0;
          ret_nxt   = S_TBL;
          state_nxt = S_FETCH;
        end
      end
      S_TBL: begin
        if (!acc_r[0]) begin
          status_nxt = ST_NO_DIR;
          state_nxt  = S_RESP;
        end else if (|tbl_ea[31:M]) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_RESP;
        end else begin
          a0_nxt    = tbl_ea[M-1:0];
          fn0_nxt   = 3'(ENTRY_BYTES);
          lim_nxt   = 3'(ENTRY_BYTES);
          cnt_nxt   = 3'd0;
          ret_nxt   = S_PTE;
          state_nxt = S_FETCH;
        end
      end
      S_PTE: begin
        if (!acc_r[0]) begin
          status_nxt = ST_NO_TBL;
          state_nxt  = S_RESP;
        end else if (!seg_r) begin
          b0_nxt = {acc_r[31:PAGE_SHIFT], va_seg[PAGE_SHIFT-1:0]};
          if (split_r) begin
            seg_nxt   = 1'b1;
            state_nxt = S_DIR;
          end else begin
            state_nxt = S_CHECK;
          end
        end else begin
          b1_nxt    = {acc_r[31:PAGE_SHIFT], va_seg[PAGE_SHIFT-1:0]};
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((|end0[32:M]) || (split_r && (|end1[32:M]))) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_RESP;
        end else begin
          a0_nxt  = b0_r[M-1:0];
          a1_nxt  = b1_r[M-1:0];
          fn0_nxt = n0_r;
          lim_nxt = len_r;
          cnt_nxt = 3'd0;
          acc_nxt = 32'd0;
          if (act_r == ACT_WRITE) begin
            state_nxt = S_WRITE;
          end else begin
            ret_nxt   = S_RESP;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // read data is the byte addressed in the cycle before
        if (cnt_r != 3'd0) begin
          acc_nxt[{lane, 3'b000} +: 8] = mem_q;
        end
        if (cnt_r == lim_r) begin
          state_nxt = ret_r;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WRITE: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == len_r - 3'd1) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    va_r     <= va_nxt;
    mid_r    <= mid_nxt;
    wd_r     <= wd_nxt;
    len_r    <= len_nxt;
    n0_r     <= n0_nxt;
    n1_r     <= n1_nxt;
    split_r  <= split_nxt;
    seg_r    <= seg_nxt;
    b0_r     <= b0_nxt;
    b1_r     <= b1_nxt;
    acc_r    <= acc_nxt;
    status_r <= status_nxt;
    a0_r     <= a0_nxt;
    a1_r     <= a1_nxt;
    fn0_r    <= fn0_nxt;
    lim_r    <= lim_nxt;
    cnt_r    <= cnt_nxt;
    if (out_load) begin
      out_rd_r <= (status_r == ST_OK && act_r == ACT_READ) ? acc_r : 32'd0;
      out_st_r <= status_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_rd_r;
  assign out_ch.status    = out_st_r;

  // -------- checks
  `TLPW_ASSERT_NOW(a_fetch_bound, state_r == S_FETCH, cnt_r <= lim_r, "fetch counter overran")
  `TLPW_ASSERT_NOW(a_write_bound, mem_we, (state_r == S_WRITE) && (cnt_r < len_r) && (status_r == ST_OK), "memory write outside a clean write pass")
  `TLPW_ASSERT_NEXT(a_resp_hold, (state_r == S_RESP) && out_valid_r && !out_ch.ready, state_r == S_RESP, "result overwritten before transfer")
  `TLPW_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state_r != S_IDLE, "accepted item did not start")

endmodule

// ===== hdl/tlpw_byte_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpw_byte_mem
// Single-port byte memory, registered read, read-before-write.
// ----------------------------------------------------------------------------
module tlpw_byte_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/two_level_page_walk_memory_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_walk_memory_test
// Drives byte reads and writes through the request channel, with and without
// address translation. Typed directed rows are checked against their expected
// result, all others against an in-bench model of the paged byte memory. Page
// tables are built through the block itself while paging is off. Random
// accesses are filtered to read no unwritten byte, walk entries included.
// ----------------------------------------------------------------------------
module two_level_page_walk_memory_test;
  import tlpw_pkg::*;

  localparam int MEM_BITS     = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int LOG_DEPTH    = 64;

  typedef struct packed {
    action_t     action;
    logic [31:0] va;
    logic [2:0]  len;
    logic [31:0] data;
  } access_t;

  typedef struct packed {
    logic [31:0] rd;
    status_t     st;
  } result_t;

  typedef struct packed {
    bit          paged;
    action_t     action;
    logic [31:0] va;
    logic [2:0]  len;
    logic [31:0] data;
    bit          typed;
    logic [31:0] rd;
    status_t     st;
  } dir_row_t;

  // directory entries go to every directory frame; the rest to their table frame
  typedef struct packed {
    bit          is_dir;
    logic [19:0] tbl;
    logic [9:0]  idx;
    logic [19:0] frame;
    bit          present;
  } pt_entry_t;

  localparam int NUM_ROWS = 28;
  localparam dir_row_t DIRECTED [0:NUM_ROWS-1] = '{
    '{1'b0, ACT_WRITE, 32'h0000_0000, 3'd4, 32'h0403_0201, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b0, ACT_READ,  32'h0000_0001, 3'd2, 32'h0000_0000, 1'b1, 32'h0000_0302, ST_OK},
    '{1'b0, ACT_WRITE, 32'h0000_FFFC, 3'd4, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b0, ACT_READ,  32'h0000_FFFE, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE},
    '{1'b0, ACT_WRITE, 32'h0000_FFFD, 3'd4, 32'h1122_3344, 1'b1, 32'h0000_0000, ST_RANGE},
    '{1'b0, ACT_READ,  32'h0000_FFFC, 3'd4, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{1'b0, ACT_READ,  32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE},
    '{1'b0, ACT_READ,  32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b0, ACT_WRITE, 32'h0000_0020, 3'd7, 32'hA5A5_A5A5, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b0, ACT_READ,  32'h0000_0020, 3'd3, 32'h0000_0000, 1'b1, 32'h00A5_A5A5, ST_OK},
    '{1'b0, ACT_WRITE, 32'h8000_0000, 3'd1, 32'h0000_00FF, 1'b1, 32'h0000_0000, ST_RANGE},
    '{1'b1, ACT_WRITE, 32'h0000_0000, 3'd4, 32'hCAFE_F00D, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'h0000_0000, 3'd4, 32'h0000_0000, 1'b1, 32'hCAFE_F00D, ST_OK},
    '{1'b1, ACT_WRITE, 32'h0000_0FFE, 3'd4, 32'h4433_2211, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'h0000_0FFE, 3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'h0000_2000, 3'd1, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_TBL},
    '{1'b1, ACT_WRITE, 32'h0000_3ABC, 3'd2, 32'h0000_BEEF, 1'b1, 32'h0000_0000, ST_RANGE},
    '{1'b1, ACT_WRITE, 32'h0000_1FFF, 3'd2, 32'h0000_7777, 1'b1, 32'h0000_0000, ST_NO_TBL},
    '{1'b1, ACT_READ,  32'h0040_0000, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_DIR},
    '{1'b1, ACT_READ,  32'h003F_FFFE, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_DIR},
    '{1'b1, ACT_READ,  32'h0080_0123, 3'd1, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE},
    '{1'b1, ACT_WRITE, 32'hFFFF_FFFE, 3'd4, 32'h8899_AABB, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'hFFFF_FFFE, 3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_WRITE, 32'h8000_0000, 3'd4, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'hFFC0_0000, 3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'h0040_0000, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_WRITE, 32'h803F_EFFE, 3'd5, 32'hF00D_BABE, 1'b1, 32'h0000_0000, ST_OK},
    '{1'b1, ACT_READ,  32'h803F_EFFE, 3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
  };

  // dir 1 absent, dir 2 points past memory, table 1 idx 2 absent, idx 3 maps past memory
  localparam int NUM_PTES = 14;
  localparam pt_entry_t PAGE_TABLE [0:NUM_PTES-1] = '{
    '{1'b1, 20'h0, 10'd0,    20'h00001, 1'b1},
    '{1'b1, 20'h0, 10'd1,    20'h00000, 1'b0},
    '{1'b1, 20'h0, 10'd2,    20'hFFFFF, 1'b1},
    '{1'b1, 20'h0, 10'd512,  20'h00002, 1'b1},
    '{1'b1, 20'h0, 10'd1023, 20'h00002, 1'b1},
    '{1'b0, 20'h1, 10'd0,    20'h00008, 1'b1},
    '{1'b0, 20'h1, 10'd1,    20'h00009, 1'b1},
    '{1'b0, 20'h1, 10'd2,    20'h00000, 1'b0},
    '{1'b0, 20'h1, 10'd3,    20'h12345, 1'b1},
    '{1'b0, 20'h1, 10'd1023, 20'h0000A, 1'b1},
    '{1'b0, 20'h2, 10'd0,    20'h0000C, 1'b1},
    '{1'b0, 20'h2, 10'd1,    20'h0000D, 1'b1},
    '{1'b0, 20'h2, 10'd1022, 20'h0000E, 1'b1},
    '{1'b0, 20'h2, 10'd1023, 20'h0000B, 1'b1}
  };

  localparam logic [19:0] DIR_FRAME_A = 20'h00000;
  localparam logic [19:0] DIR_FRAME_B = 20'h0000F;

  localparam int NUM_MAPPED = 11;
  localparam logic [31:0] MAPPED_PAGES [0:NUM_MAPPED-1] = '{
    32'h0000_0000, 32'h0000_1000, 32'h003F_F000, 32'hFFC0_0000, 32'hFFC0_1000,
    32'hFFFF_E000, 32'hFFFF_F000, 32'h8000_0000, 32'h8000_1000, 32'h803F_E000,
    32'h803F_F000
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  tlpw_in_if  in_ch ();
  tlpw_out_if out_ch ();

  two_level_page_walk_memory #(
    .MEM_ADDR_BITS(MEM_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // memory model
  logic [7:0]  phys_mem     [0:(1<<MEM_BITS)-1];
  bit          phys_written [0:(1<<MEM_BITS)-1];
  bit          paging_model;
  logic [19:0] dir_frame_model;

  result_t     pending_results [$];
  logic [31:0] write_log [$];
  int          bad_results;
  int          results_seen;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] load_entry(input logic [31:0] ea, inout bit bad);
    logic [31:0] e;
    logic [15:0] a;
    e = '0;
    for (int i = 0; i < 4; i++) begin
      a = 16'(ea + i);
      if (!phys_written[a]) bad = 1'b1;
      e[8*i +: 8] = phys_mem[a];
    end
    return e;
  endfunction

  function automatic logic [1:0] walk_va(input logic [31:0] va, output logic [31:0] pa,
                                         inout bit bad);
    logic [31:0] ea;
    logic [31:0] e;
    pa = '0;
    ea = {dir_frame_model, 12'h000} + {20'h0, va[31:22], 2'b00};
    if ((ea >> MEM_BITS) != 0) return ST_RANGE;
    e = load_entry(ea, bad);
    if (!e[0]) return ST_NO_DIR;
    ea = {e[31:12], 12'h000} + {20'h0, va[21:12], 2'b00};
    if ((ea >> MEM_BITS) != 0) return ST_RANGE;
    e = load_entry(ea, bad);
    if (!e[0]) return ST_NO_TBL;
    pa = {e[31:12], va[11:0]};
    return ST_OK;
  endfunction

  // commit = 0 is a dry run: memory is left alone, bad flags reads of unwritten bytes
  function automatic void predict_access(input access_t it, input bit commit,
                                         output result_t res, output bit bad);
    int          n;
    logic [31:0] last;
    logic [31:0] mid;
    logic [31:0] len_l;
    logic [31:0] b0;
    logic [31:0] b1;
    logic [32:0] pa [4];
    logic [1:0]  st;
    logic [31:0] rd;
    logic [15:0] a;
    n   = (it.len > 3'd4) ? 4 : int'(it.len);
    st  = ST_OK;
    rd  = '0;
    bad = 1'b0;
    b0  = '0;
    b1  = '0;
    if (n != 0) begin
      if (paging_model) begin
        last = it.va + n - 1;
        if (((it.va ^ last) >> 12) == 0) begin
          st = walk_va(it.va, b0, bad);
          for (int i = 0; i < n; i++) pa[i] = {1'b0, b0} + 33'(i);
        end else begin
          mid   = last & ~32'hfff;
          len_l = mid - it.va;
          st = walk_va(it.va, b0, bad);
          if (st == ST_OK) st = walk_va(mid, b1, bad);
          for (int i = 0; i < n; i++)
            pa[i] = (i < len_l) ? {1'b0, b0} + 33'(i) : {1'b0, b1} + 33'(i - len_l);
        end
      end else begin
        for (int i = 0; i < n; i++) pa[i] = {1'b0, it.va} + 33'(i);
      end
      if (st == ST_OK) begin
        for (int i = 0; i < n; i++)
          if ((pa[i] >> MEM_BITS) != 0) st = ST_RANGE;
      end
      if (st == ST_OK) begin
        for (int i = 0; i < n; i++) begin
          a = pa[i][15:0];
          if (it.action == ACT_WRITE) begin
            if (commit) begin
              phys_mem[a]     = it.data[8*i +: 8];
              phys_written[a] = 1'b1;
            end
          end else begin
            if (!phys_written[a]) bad = 1'b1;
            rd[8*i +: 8] = phys_mem[a];
          end
        end
      end
    end
    res.rd = (st == ST_OK) ? rd : 32'h0;
    res.st = status_t'(st);
  endfunction

  task automatic send_access(input access_t it, input bit typed, input result_t typed_res);
    result_t res;
    bit      bad;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= it.action;
    in_ch.virt_addr  <= it.va;
    in_ch.access_len <= it.len;
    in_ch.write_data <= it.data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_access(it, 1'b1, res, bad);
    pending_results.push_back(typed ? typed_res : res);
    if (it.action == ACT_WRITE && res.st == ST_OK && it.len != 3'd0) begin
      write_log.push_back(it.va);
      if (write_log.size() > LOG_DEPTH) void'(write_log.pop_front());
    end
  endtask

  task automatic pick_access(output access_t it);
    access_t c;
    result_t r;
    bit      bad;
    int      pick;
    int      tries;
    tries = 0;
    do begin
      pick     = $urandom_range(0, 99);
      c.action = action_t'($urandom_range(0, 1));
      c.len    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
      c.data   = $urandom;
      if (pick < 8) begin
        c.va = $urandom;
      end else if (pick < 45 && write_log.size() > 0) begin
        // read back near something written earlier
        c.action = ACT_READ;
        c.va = write_log[$urandom_range(0, write_log.size() - 1)] + $urandom_range(0, 3);
      end else if (paging_model) begin
        if (pick < 60) begin
          case ($urandom_range(0, 3))
            0:       c.va = {20'h00002, 12'($urandom)};
            1:       c.va = {20'h00003, 12'($urandom)};
            2:       c.va = {10'd1, 22'($urandom)};
            default: c.va = {10'd2, 22'($urandom)};
          endcase
        end else begin
          c.va = MAPPED_PAGES[$urandom_range(0, NUM_MAPPED - 1)];
          c.va[11:0] = ($urandom_range(0, 9) < 3) ? 12'($urandom_range(12'hFFC, 12'hFFF))
                                                  : 12'($urandom);
          c.action = ($urandom_range(0, 9) < 7) ? ACT_WRITE : ACT_READ;
        end
      end else begin
        if (pick < 60) begin
          c.va = $urandom_range((1 << MEM_BITS) - 8, (1 << MEM_BITS) - 1);
        end else begin
          c.va = $urandom_range(0, (1 << MEM_BITS) - 1);
          c.action = ($urandom_range(0, 9) < 7) ? ACT_WRITE : ACT_READ;
        end
      end
      predict_access(c, 1'b0, r, bad);
      tries++;
    end while (bad && tries < 16);
    if (bad) begin
      // writes to mapped pages only walk entries that exist
      c.action = ACT_WRITE;
      if (paging_model) begin
        c.len = 3'($urandom_range(1, 4));
        c.va  = MAPPED_PAGES[$urandom_range(0, NUM_MAPPED - 1)] + $urandom_range(0, 12'hFFC);
      end
    end
    it = c;
  endtask

  task automatic run_random(input int count);
    access_t it;
    for (int k = 0; k < count; k++) begin
      pick_access(it);
      send_access(it, 1'b0, '0);
    end
  endtask

  task automatic run_directed(input bit paged);
    access_t it;
    result_t typed_res;
    for (int k = 0; k < NUM_ROWS; k++) begin
      if (DIRECTED[k].paged == paged) begin
        it.action    = DIRECTED[k].action;
        it.va        = DIRECTED[k].va;
        it.len       = DIRECTED[k].len;
        it.data      = DIRECTED[k].data;
        typed_res.rd = DIRECTED[k].rd;
        typed_res.st = DIRECTED[k].st;
        send_access(it, DIRECTED[k].typed, typed_res);
      end
    end
  endtask

  task automatic build_page_tables();
    access_t it;
    for (int k = 0; k < NUM_PTES; k++) begin
      it.action = ACT_WRITE;
      it.len    = 3'd4;
      it.data   = PAGE_TABLE[k].present ? {PAGE_TABLE[k].frame, 11'($urandom), 1'b1}
                                        : {31'($urandom), 1'b0};
      if (PAGE_TABLE[k].is_dir) begin
        it.va = {DIR_FRAME_A, 12'h000} + {20'h0, PAGE_TABLE[k].idx, 2'b00};
        send_access(it, 1'b0, '0);
        it.va = {DIR_FRAME_B, 12'h000} + {20'h0, PAGE_TABLE[k].idx, 2'b00};
      end else begin
        it.va = {PAGE_TABLE[k].tbl, 12'h000} + {20'h0, PAGE_TABLE[k].idx, 2'b00};
      end
      send_access(it, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_log.delete();
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == REG_PAGING_ON) paging_model = value[0];
    else if (addr == REG_DIR_BASE) dir_frame_model = value[19:0];
    // leave the bus idle before the next write
    @(posedge clk);
  endtask

  function automatic void note_bad(input string what);
    bad_results++;
    if (bad_results <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // result side: random stalls plus one long hold to back the block up
  initial begin
    int      stall_left;
    bit      hold_done;
    result_t exp_res;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_bad($sformatf("unexpected result read_data %h status %0d",
                             out_ch.read_data, out_ch.status));
        end else begin
          exp_res = pending_results.pop_front();
          if (out_ch.read_data !== exp_res.rd || out_ch.status !== exp_res.st)
            note_bad($sformatf("bad result: read_data exp %h got %h, status exp %0d got %0d",
                               exp_res.rd, out_ch.read_data, exp_res.st, out_ch.status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    paging_model     = 1'b0;
    dir_frame_model  = '0;
    bad_results      = 0;
    results_seen     = 0;
    no_idle          = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_READ;
    in_ch.virt_addr  <= '0;
    in_ch.access_len <= '0;
    in_ch.write_data <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // physical addressing straight out of reset
    run_directed(1'b0);
    run_random(450);
    drain();
    build_page_tables();
    drain();

    cfg_write(REG_DIR_BASE, {12'h0, DIR_FRAME_A});
    cfg_write(REG_PAGING_ON, 32'h1);
    run_directed(1'b1);
    run_random(600);
    drain();

    // same mappings through the directory in the last frame of memory
    cfg_write(REG_DIR_BASE, {12'h0, DIR_FRAME_B});
    run_random(300);
    drain();

    // directory far past memory: every walk faults on its first entry
    cfg_write(REG_DIR_BASE, 32'hFFFF_FFFF);
    run_random(100);
    drain();

    cfg_write(REG_PAGING_ON, 32'h0);
    run_random(150);
    no_idle = 1'b1;
    run_random(150);
    drain();

    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
